[sv/mlap_pkg.sv]
// mlap_pkg: shared types, constants and helpers of the madt local apic parser
// used by every module of the block; no dependencies
package mlap_pkg;

   localparam int OFFSET_W = 17;
   localparam logic [OFFSET_W-1:0] OFFSET_MAX = 17'h1FFFF;
   localparam logic [OFFSET_W-1:0] HDR_BYTES = 17'd44;
   localparam logic [OFFSET_W-1:0] LEN_FIRST = 17'd4;
   localparam logic [OFFSET_W-1:0] LEN_LAST = 17'd7;
   localparam logic [OFFSET_W-1:0] BASE_FIRST = 17'd36;
   localparam logic [OFFSET_W-1:0] BASE_LAST = 17'd39;
   localparam logic [7:0] MIN_CPU_ENTRY = 8'd8;
   localparam logic [7:0] MIN_ENTRY = 8'd2;
   localparam logic [7:0] TYPE_LOCAL_APIC = 8'd0;
   localparam logic [31:0] MIN_TABLE_LEN = 32'd44;

   localparam logic KIND_CPU = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // one queue word: an optional cpu record followed by an optional summary
   typedef struct packed {
      logic        has_cpu;
      logic [3:0]  cpu_index;
      logic [7:0]  processor_number;
      logic [7:0]  local_apic_id;
      logic [31:0] entry_flags;
      logic        is_bootstrap;
      logic        has_sum;
      logic [4:0]  cpus_found;
      logic [31:0] apic_base_address;
      logic        used_fallback;
   } mlap_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } mlap_qstat_type;

   typedef struct packed {
      logic        record_kind;
      logic [3:0]  cpu_index;
      logic [7:0]  processor_number;
      logic [7:0]  local_apic_id;
      logic [31:0] entry_flags;
      logic        cpu_enabled;
      logic        is_bootstrap;
      logic [4:0]  cpus_found;
      logic [31:0] apic_base_address;
      logic        used_fallback;
      logic        run_end;
   } mlap_result_type;

   function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] pos,
                                            input logic [7:0] b);
      logic [31:0] r;
      r = word;
      r[{pos, 3'b000} +: 8] = b;
      return r;
   endfunction

endpackage

[sv/mlap_req_if.sv]
// mlap_req_if: byte stream channel into the parser
// depends on nothing
interface mlap_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] table_byte;
   logic       final_byte;

   modport source (output valid, output table_byte, output final_byte, input ready);
   modport sink (input valid, input table_byte, input final_byte, output ready);
endinterface

[sv/mlap_rsp_if.sv]
// mlap_rsp_if: result channel out of the parser, cpu records and summaries
// depends on nothing
interface mlap_rsp_if;
   logic        valid;
   logic        ready;
   logic        record_kind;
   logic [3:0]  cpu_index;
   logic [7:0]  processor_number;
   logic [7:0]  local_apic_id;
   logic [31:0] entry_flags;
   logic        cpu_enabled;
   logic        is_bootstrap;
   logic [4:0]  cpus_found;
   logic [31:0] apic_base_address;
   logic        used_fallback;
   logic        run_end;

   modport source (output valid, output record_kind, output cpu_index,
                   output processor_number, output local_apic_id, output entry_flags,
                   output cpu_enabled, output is_bootstrap, output cpus_found,
                   output apic_base_address, output used_fallback, output run_end,
                   input ready);
   modport sink (input valid, input record_kind, input cpu_index,
                 input processor_number, input local_apic_id, input entry_flags,
                 input cpu_enabled, input is_bootstrap, input cpus_found,
                 input apic_base_address, input used_fallback, input run_end,
                 output ready);
endinterface

[sv/mlap_front.sv]
// mlap_front: accepts table bytes, tracks header and entry walk, builds queue words
// depends on mlap_pkg and mlap_req_if
module mlap_front #(
   parameter int MAX_CPUS = 16,
   parameter int MAX_TABLE_BYTES = 65536
) (
   input  logic                    clock,
   input  logic                    reset,
   mlap_req_if.sink                req_ch,
   input  mlap_pkg::mlap_qstat_type q_stat,
   output logic                    push,
   output mlap_pkg::mlap_entry_type push_data
);
   import mlap_pkg::*;

   localparam int CW = $clog2(MAX_CPUS + 1);
   localparam logic [CW-1:0] CPU_LIMIT = CW'(MAX_CPUS);
   localparam logic [31:0] MAX_LEN = 32'(MAX_TABLE_BYTES);

   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [31:0]         decl_ff, decl_in;
   logic [31:0]         base_ff, base_in;
   logic [OFFSET_W-1:0] es_ff, es_in;
   logic [7:0]          type_ff, type_in;
   logic [7:0]          len_ff, len_in;
   logic [7:0]          proc_ff, proc_in;
   logic [7:0]          apic_ff, apic_in;
   logic [31:0]         flags_ff, flags_in;
   logic [CW-1:0]       found_ff, found_in;
   logic                stopped_ff, stopped_in;

   logic                accept;
   logic [7:0]          b;
   logic                len_ok;
   logic                walk;
   logic [OFFSET_W-1:0] rel;
   logic                fallback;
   logic [CW+3:0]       idx_wide;
   logic [CW+4:0]       cnt_wide;

   assign req_ch.ready = !q_stat.full;
   assign accept = req_ch.valid && req_ch.ready;
   assign b = req_ch.table_byte;
   assign rel = offset_ff - es_ff;
   assign idx_wide = {4'b0000, found_ff};

   always_comb begin
      offset_in = (offset_ff == OFFSET_MAX) ? offset_ff : offset_ff + 1'b1;
      decl_in = decl_ff;
      base_in = base_ff;
      es_in = es_ff;
      type_in = type_ff;
      len_in = len_ff;
      proc_in = proc_ff;
      apic_in = apic_ff;
      flags_in = flags_ff;
      found_in = found_ff;
      stopped_in = stopped_ff;
      push_data = '0;

      if (offset_ff >= LEN_FIRST && offset_ff <= LEN_LAST) begin
         decl_in = put_byte(decl_ff, offset_ff[1:0], b);
      end
      if (offset_ff >= BASE_FIRST && offset_ff <= BASE_LAST) begin
         base_in = put_byte(base_ff, offset_ff[1:0], b);
      end

      len_ok = decl_in >= MIN_TABLE_LEN && decl_in <= MAX_LEN;
      walk = offset_ff >= HDR_BYTES && len_ok && !stopped_ff &&
             {15'b0, offset_ff} < decl_in && offset_ff >= es_ff;

      if (walk) begin
         if (rel == '0) begin
            type_in = b;
         end else begin
            if (rel == 17'd1) begin
               len_in = b;
               if (b < MIN_ENTRY ||
                   ({16'b0, es_ff} + {25'b0, b}) > {1'b0, decl_in}) begin
                  stopped_in = 1'b1;
               end
            end else if (rel == 17'd2) begin
               proc_in = b;
            end else if (rel == 17'd3) begin
               apic_in = b;
            end else if (rel <= 17'd7) begin
               flags_in = put_byte(flags_ff, rel[1:0], b);
            end
            if (!stopped_in && (rel + 1'b1) == {9'b0, len_in}) begin
               if (type_in == TYPE_LOCAL_APIC && len_in >= MIN_CPU_ENTRY &&
                   found_ff < CPU_LIMIT) begin
                  push_data.has_cpu = 1'b1;
                  push_data.cpu_index = idx_wide[3:0];
                  push_data.processor_number = proc_in;
                  push_data.local_apic_id = apic_in;
                  push_data.entry_flags = flags_in;
                  push_data.is_bootstrap = (found_ff == '0);
                  found_in = found_ff + 1'b1;
               end
               es_in = es_ff + {9'b0, len_in};
            end
         end
      end

      cnt_wide = {5'b00000, found_in};
      fallback = !len_ok || found_in == '0;

      if (req_ch.final_byte) begin
         push_data.has_sum = 1'b1;
         push_data.cpus_found = fallback ? 5'd1 : cnt_wide[4:0];
         push_data.apic_base_address = fallback ? 32'd0 : base_in;
         push_data.used_fallback = fallback;
         // next table starts from scratch
         offset_in = '0;
         decl_in = '0;
         base_in = '0;
         es_in = HDR_BYTES;
         type_in = '0;
         len_in = '0;
         proc_in = '0;
         apic_in = '0;
         flags_in = '0;
         found_in = '0;
         stopped_in = 1'b0;
      end
   end

   assign push = accept && (push_data.has_cpu || push_data.has_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         decl_ff <= '0;
         base_ff <= '0;
         es_ff <= HDR_BYTES;
         type_ff <= '0;
         len_ff <= '0;
         proc_ff <= '0;
         apic_ff <= '0;
         flags_ff <= '0;
         found_ff <= '0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         offset_ff <= offset_in;
         decl_ff <= decl_in;
         base_ff <= base_in;
         es_ff <= es_in;
         type_ff <= type_in;
         len_ff <= len_in;
         proc_ff <= proc_in;
         apic_ff <= apic_in;
         flags_ff <= flags_in;
         found_ff <= found_in;
         stopped_ff <= stopped_in;
      end
   end

   a_found_bounded: assert property (@(posedge clock) disable iff (reset)
      found_ff <= CPU_LIMIT)
      else $error("cpu count passed its limit");

   a_entry_in_table: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_ch.final_byte && walk && !stopped_in && es_in != es_ff) |->
      {15'b0, es_in} <= decl_in)
      else $error("entry walk ran past the table length");

endmodule

[sv/mlap_queue.sv]
// mlap_queue: small fifo of queue words between front and back
// depends on mlap_pkg
module mlap_queue #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mlap_pkg::mlap_entry_type push_data,
   input  logic                     pop,
   output mlap_pkg::mlap_entry_type head,
   output mlap_pkg::mlap_qstat_type q_stat
);
   import mlap_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [NW-1:0] FULL_COUNT = NW'(DEPTH);

   mlap_entry_type      slots_ff [DEPTH];
   logic [PW-1:0]       wr_ff, wr_in;
   logic [PW-1:0]       rd_ff, rd_in;
   logic [NW-1:0]       count_ff, count_in;

   assign q_stat.full = (count_ff == FULL_COUNT);
   assign q_stat.empty = (count_ff == '0);
   assign head = slots_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_SLOT) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_SLOT) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("pop from empty queue");

endmodule

[sv/mlap_back.sv]
// mlap_back: drains queue words into result words, record before summary
// depends on mlap_pkg and mlap_rsp_if
module mlap_back (
   input  logic                     clock,
   input  logic                     reset,
   input  mlap_pkg::mlap_entry_type head,
   input  mlap_pkg::mlap_qstat_type q_stat,
   output logic                     pop,
   mlap_rsp_if.source               rsp_ch
);
   import mlap_pkg::*;

   logic            valid_ff, valid_in;
   logic            phase_ff, phase_in;
   mlap_result_type out_ff, out_in;
   logic            load;
   logic            cpu_now;

   assign load = !valid_ff || rsp_ch.ready;
   assign cpu_now = head.has_cpu && !phase_ff;

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      out_in = out_ff;
      pop = 1'b0;
      if (load) begin
         valid_in = !q_stat.empty;
         if (!q_stat.empty) begin
            out_in = '0;
            if (cpu_now) begin
               out_in.record_kind = KIND_CPU;
               out_in.cpu_index = head.cpu_index;
               out_in.processor_number = head.processor_number;
               out_in.local_apic_id = head.local_apic_id;
               out_in.entry_flags = head.entry_flags;
               out_in.cpu_enabled = head.entry_flags[0];
               out_in.is_bootstrap = head.is_bootstrap;
               out_in.run_end = !head.has_sum;
            end else begin
               out_in.record_kind = KIND_SUMMARY;
               out_in.cpus_found = head.cpus_found;
               out_in.apic_base_address = head.apic_base_address;
               out_in.used_fallback = head.used_fallback;
               out_in.run_end = 1'b1;
            end
            // hold the word for its summary after sending the record
            phase_in = cpu_now && head.has_sum;
            pop = !(cpu_now && head.has_sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.record_kind = out_ff.record_kind;
   assign rsp_ch.cpu_index = out_ff.cpu_index;
   assign rsp_ch.processor_number = out_ff.processor_number;
   assign rsp_ch.local_apic_id = out_ff.local_apic_id;
   assign rsp_ch.entry_flags = out_ff.entry_flags;
   assign rsp_ch.cpu_enabled = out_ff.cpu_enabled;
   assign rsp_ch.is_bootstrap = out_ff.is_bootstrap;
   assign rsp_ch.cpus_found = out_ff.cpus_found;
   assign rsp_ch.apic_base_address = out_ff.apic_base_address;
   assign rsp_ch.used_fallback = out_ff.used_fallback;
   assign rsp_ch.run_end = out_ff.run_end;

   a_summary_ends_run: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && out_ff.record_kind == KIND_SUMMARY) |-> out_ff.run_end)
      else $error("summary without run end");

   a_phase_holds_word: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (!q_stat.empty && head.has_sum))
      else $error("pending summary lost from queue");

endmodule

[sv/madt_local_apic_parser_top.sv]
// madt_local_apic_parser_top: parser top level, front, queue and back joined
// depends on mlap_pkg, mlap_req_if, mlap_rsp_if, mlap_front, mlap_queue, mlap_back
//
// The block takes an acpi madt one byte per cycle on req_ch, starting at offset zero,
// and keeps taking a byte every cycle while its result queue of QUEUE_DEPTH words has
// room; a byte is parsed in the cycle it is taken. Results leave through a registered
// stage on rsp_ch at one per cycle while the receiver is ready, so a final byte that
// also completes a cpu entry yields two result words (record, then summary); this
// output side is the only thing that can push back on the input. The first result of
// a byte is written into the queue and then into the registered output stage.
module madt_local_apic_parser_top #(
   parameter int MAX_CPUS = 16,
   parameter int MAX_TABLE_BYTES = 65536,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   mlap_req_if.sink    req_ch,
   mlap_rsp_if.source  rsp_ch
);
   import mlap_pkg::*;

   logic           push;
   logic           pop;
   mlap_entry_type push_data;
   mlap_entry_type head;
   mlap_qstat_type q_stat;

   mlap_front #(
      .MAX_CPUS(MAX_CPUS),
      .MAX_TABLE_BYTES(MAX_TABLE_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .q_stat(q_stat),
      .push(push),
      .push_data(push_data)
   );

   mlap_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .pop(pop),
      .head(head),
      .q_stat(q_stat)
   );

   mlap_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .q_stat(q_stat),
      .pop(pop),
      .rsp_ch(rsp_ch)
   );

endmodule

[test/madt_local_apic_parser_top_tb.sv]
// madt_local_apic_parser_top_tb: self-checking bench for the madt local apic parser
// streams directed and random madt images through req_ch and checks every rsp_ch word
// against an in-bench model of the walk; depends on mlap_pkg, mlap_req_if, mlap_rsp_if, madt_local_apic_parser_top
module madt_local_apic_parser_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mlap_pkg::*;

   localparam int MAX_CPUS = 16;
   localparam int MAX_TABLE_BYTES = 65536;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 4000;
   localparam int RANDOM_BYTES = 300;
   localparam int RANDOM_WORDS = 12;

   typedef enum logic [2:0] {
      TAIL_NONE,
      TAIL_BAD_LEN,
      TAIL_OVERRUN,
      TAIL_LONE_TYPE,
      TAIL_SKIPPED
   } tail_kind_type;

   typedef struct packed {
      logic [31:0]   hdr_len;
      bit            auto_len;
      logic [31:0]   supplied;
      logic [31:0]   apic_base;
      logic [7:0]    cpu_type;
      logic [7:0]    cpu_entries;
      logic [7:0]    cpu_len;
      tail_kind_type tail;
      bit            hold;
      bit            pinned;
      logic [4:0]    pin_count;
      logic [31:0]   pin_base;
      bit            pin_fb;
   } madt_case_type;

   // hdr_len auto supplied base type n len tail hold pinned count base fallback
   madt_case_type directed_cases [17] = '{
      '{32'd52, 1'b0, 32'd1, 32'h0, 8'd0, 8'd0, 8'd8, TAIL_NONE,
        1'b0, 1'b1, 5'd1, 32'h0, 1'b1},
      '{32'd52, 1'b0, 32'd6, 32'h1234_5678, 8'd0, 8'd1, 8'd8, TAIL_NONE,
        1'b0, 1'b1, 5'd1, 32'h0, 1'b1},
      '{32'd43, 1'b0, 32'd52, 32'hFEE0_0000, 8'd0, 8'd1, 8'd8, TAIL_NONE,
        1'b0, 1'b1, 5'd1, 32'h0, 1'b1},
      '{32'd65537, 1'b0, 32'd60, 32'hFEE0_0000, 8'd0, 8'd2, 8'd8, TAIL_NONE,
        1'b0, 1'b1, 5'd1, 32'h0, 1'b1},
      '{32'd44, 1'b0, 32'd0, 32'hFEE0_0000, 8'd0, 8'd0, 8'd8, TAIL_NONE,
        1'b0, 1'b1, 5'd1, 32'h0, 1'b1},
      '{32'd0, 1'b1, 32'd0, 32'hFFFF_FFFF, 8'd0, 8'd1, 8'd8, TAIL_NONE,
        1'b0, 1'b1, 5'd1, 32'hFFFF_FFFF, 1'b0},
      '{32'd0, 1'b1, 32'd0, 32'h0, 8'd0, 8'd1, 8'd255, TAIL_NONE,
        1'b0, 1'b1, 5'd1, 32'h0, 1'b0},
      '{32'd0, 1'b1, 32'd0, 32'hFEE0_0000, 8'd0, 8'd17, 8'd8, TAIL_NONE,
        1'b1, 1'b1, 5'd16, 32'hFEE0_0000, 1'b0},
      '{32'd0, 1'b1, 32'd0, 32'hFEE0_0000, 8'd0, 8'd1, 8'd8, TAIL_BAD_LEN,
        1'b0, 1'b1, 5'd1, 32'hFEE0_0000, 1'b0},
      '{32'd0, 1'b1, 32'd0, 32'hFEE0_0000, 8'd0, 8'd1, 8'd8, TAIL_OVERRUN,
        1'b0, 1'b1, 5'd1, 32'hFEE0_0000, 1'b0},
      '{32'd0, 1'b1, 32'd0, 32'hFEE0_0000, 8'd0, 8'd1, 8'd8, TAIL_LONE_TYPE,
        1'b0, 1'b1, 5'd1, 32'hFEE0_0000, 1'b0},
      '{32'd0, 1'b1, 32'd0, 32'hFEE0_0000, 8'd0, 8'd1, 8'd8, TAIL_SKIPPED,
        1'b0, 1'b1, 5'd1, 32'hFEE0_0000, 1'b0},
      '{32'd60, 1'b0, 32'd56, 32'hFEC0_0000, 8'd0, 8'd2, 8'd8, TAIL_NONE,
        1'b0, 1'b1, 5'd1, 32'hFEC0_0000, 1'b0},
      '{32'd52, 1'b0, 32'd60, 32'hFEC0_0000, 8'd0, 8'd2, 8'd8, TAIL_NONE,
        1'b0, 1'b1, 5'd1, 32'hFEC0_0000, 1'b0},
      '{32'd0, 1'b1, 32'd0, 32'hFEC0_0000, 8'd1, 8'd2, 8'd8, TAIL_NONE,
        1'b0, 1'b1, 5'd1, 32'h0, 1'b1},
      '{32'd65536, 1'b0, 32'd60, 32'hFEE0_1000, 8'd0, 8'd3, 8'd8, TAIL_NONE,
        1'b0, 1'b0, 5'd0, 32'h0, 1'b0},
      '{32'd52, 1'b0, 32'd60, 32'hFEE0_2000, 8'd0, 8'd1, 8'd8, TAIL_NONE,
        1'b0, 1'b1, 5'd1, 32'hFEE0_2000, 1'b0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   mlap_req_if req_ch ();
   mlap_rsp_if rsp_ch ();

   madt_local_apic_parser_top #(
      .MAX_CPUS(MAX_CPUS),
      .MAX_TABLE_BYTES(MAX_TABLE_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // walk state of the table currently streaming
   logic [16:0] walk_offset;
   logic [31:0] walk_len;
   logic [31:0] walk_base;
   logic [31:0] walk_start;
   logic [7:0]  walk_type;
   logic [7:0]  walk_entry_len;
   logic [7:0]  walk_proc;
   logic [7:0]  walk_apic;
   logic [31:0] walk_flags;
   logic [4:0]  walk_found;
   logic        walk_stopped;

   mlap_result_type records_due [$];
   logic [7:0]      madt_bytes [$];
   madt_case_type   pinned_case;
   bit              pin_armed = 1'b0;

   int unsigned bytes_taken = 0;
   int unsigned words_taken = 0;
   int unsigned fault_count = 0;
   int unsigned burst_left = 0;
   int unsigned quiet_cycles = 0;
   bit          hold_ask = 1'b0;
   int unsigned hold_left = 0;
   int unsigned stall_mode = 0;
   int unsigned stall_phase_left = 0;

   mlap_result_type got, want;

   task clear_walk();
      walk_offset = '0;
      walk_len = '0;
      walk_base = '0;
      walk_start = 32'(HDR_BYTES);
      walk_type = '0;
      walk_entry_len = '0;
      walk_proc = '0;
      walk_apic = '0;
      walk_flags = '0;
      walk_found = '0;
      walk_stopped = 1'b0;
   endtask

   task madt_walk_byte(input logic [7:0] b, input logic fin);
      logic [31:0]     off;
      logic [31:0]     rel;
      logic            len_ok;
      logic            fallback;
      mlap_result_type word [2];
      int              n;
      n = 0;
      off = 32'(walk_offset);
      if (off >= LEN_FIRST && off <= LEN_LAST) walk_len[8*(off - LEN_FIRST) +: 8] = b;
      if (off >= BASE_FIRST && off <= BASE_LAST) walk_base[8*(off - BASE_FIRST) +: 8] = b;
      len_ok = walk_len >= MIN_TABLE_LEN && walk_len <= MAX_TABLE_BYTES;
      if (off >= HDR_BYTES && len_ok && !walk_stopped && off < walk_len &&
          off >= walk_start) begin
         rel = off - walk_start;
         if (rel == 0) begin
            walk_type = b;
         end else begin
            if (rel == 1) begin
               walk_entry_len = b;
               if (b < MIN_ENTRY || walk_start + b > walk_len) walk_stopped = 1'b1;
            end else if (rel == 2) begin
               walk_proc = b;
            end else if (rel == 3) begin
               walk_apic = b;
            end else if (rel <= 7) begin
               walk_flags[8*(rel - 4) +: 8] = b;
            end
            if (!walk_stopped && rel + 1 == walk_entry_len) begin
               if (walk_type == TYPE_LOCAL_APIC && walk_entry_len >= MIN_CPU_ENTRY &&
                   walk_found < MAX_CPUS) begin
                  word[n] = '0;
                  word[n].record_kind = KIND_CPU;
                  word[n].cpu_index = walk_found[3:0];
                  word[n].processor_number = walk_proc;
                  word[n].local_apic_id = walk_apic;
                  word[n].entry_flags = walk_flags;
                  word[n].cpu_enabled = walk_flags[0];
                  word[n].is_bootstrap = (walk_found == 0);
                  n++;
                  walk_found++;
               end
               walk_start += walk_entry_len;
            end
         end
      end
      if (walk_offset != OFFSET_MAX) walk_offset++;
      if (fin) begin
         fallback = !len_ok || walk_found == 0;
         word[n] = '0;
         word[n].record_kind = KIND_SUMMARY;
         if (pin_armed) begin
            word[n].cpus_found = pinned_case.pin_count;
            word[n].apic_base_address = pinned_case.pin_base;
            word[n].used_fallback = pinned_case.pin_fb;
            pin_armed = 1'b0;
         end else begin
            word[n].cpus_found = fallback ? 5'd1 : walk_found;
            word[n].apic_base_address = fallback ? 32'h0 : walk_base;
            word[n].used_fallback = fallback;
         end
         n++;
         clear_walk();
      end
      if (n > 0) word[n-1].run_end = 1'b1;
      for (int k = 0; k < n; k++) records_due.push_back(word[k]);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.table_byte <= b;
      req_ch.final_byte <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      madt_walk_byte(b, fin);
      bytes_taken++;
      @(negedge clock);
   endtask

   task automatic run_case(input madt_case_type c);
      logic [31:0] len;
      int unsigned total;
      madt_bytes.delete();
      repeat (HDR_BYTES) madt_bytes.push_back(8'($urandom));
      repeat (c.cpu_entries) begin
         madt_bytes.push_back(c.cpu_type);
         madt_bytes.push_back(c.cpu_len);
         for (int k = 2; k < c.cpu_len; k++) madt_bytes.push_back(8'($urandom));
      end
      case (c.tail)
         TAIL_BAD_LEN: begin
            madt_bytes.push_back(TYPE_LOCAL_APIC);
            madt_bytes.push_back(MIN_ENTRY - 8'd1);
         end
         TAIL_OVERRUN: begin
            madt_bytes.push_back(TYPE_LOCAL_APIC);
            madt_bytes.push_back(8'd200);
         end
         TAIL_LONE_TYPE: begin
            madt_bytes.push_back(TYPE_LOCAL_APIC);
         end
         TAIL_SKIPPED: begin
            madt_bytes.push_back(8'd1);
            madt_bytes.push_back(8'd10);
            repeat (8) madt_bytes.push_back(8'($urandom));
            madt_bytes.push_back(TYPE_LOCAL_APIC);
            madt_bytes.push_back(8'd6);
            repeat (4) madt_bytes.push_back(8'($urandom));
         end
         default: begin
         end
      endcase
      len = c.auto_len ? 32'(madt_bytes.size()) : c.hdr_len;
      total = (c.supplied != 0) ? c.supplied : len;
      while (madt_bytes.size() < total) madt_bytes.push_back(8'($urandom));
      while (madt_bytes.size() > total) void'(madt_bytes.pop_back());
      for (int k = 0; k < 4; k++) begin
         if (LEN_FIRST + k < total) madt_bytes[LEN_FIRST + k] = len[8*k +: 8];
         if (BASE_FIRST + k < total) madt_bytes[BASE_FIRST + k] = c.apic_base[8*k +: 8];
      end
      pinned_case = c;
      pin_armed = c.pinned;
      if (c.hold) hold_ask = 1'b1;
      foreach (madt_bytes[k]) send_byte(madt_bytes[k], k == madt_bytes.size() - 1);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (records_due.size() != 0) @(negedge clock);
   endtask

   function automatic string fmt_word(input mlap_result_type r);
      return $sformatf({"kind=%0d idx=%0d proc=%h apic=%h flags=%h en=%0d bsp=%0d ",
                        "n=%0d base=%h fb=%0d end=%0d"},
                       r.record_kind, r.cpu_index, r.processor_number, r.local_apic_id,
                       r.entry_flags, r.cpu_enabled, r.is_bootstrap, r.cpus_found,
                       r.apic_base_address, r.used_fallback, r.run_end);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.record_kind = rsp_ch.record_kind;
         got.cpu_index = rsp_ch.cpu_index;
         got.processor_number = rsp_ch.processor_number;
         got.local_apic_id = rsp_ch.local_apic_id;
         got.entry_flags = rsp_ch.entry_flags;
         got.cpu_enabled = rsp_ch.cpu_enabled;
         got.is_bootstrap = rsp_ch.is_bootstrap;
         got.cpus_found = rsp_ch.cpus_found;
         got.apic_base_address = rsp_ch.apic_base_address;
         got.used_fallback = rsp_ch.used_fallback;
         got.run_end = rsp_ch.run_end;
         words_taken++;
         if (records_due.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) $display("unexpected word: %s", fmt_word(got));
         end else begin
            want = records_due.pop_front();
            if (got !== want) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("word mismatch at %0t", $realtime);
                  $display("  expected %s", fmt_word(want));
                  $display("  actual   %s", fmt_word(got));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("madt_local_apic_parser_top_tb: errors");
         $finish;
      end
   end

   // receiver: long hold on request, otherwise changing stall patterns
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ask) begin
            hold_ask = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (stall_phase_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_phase_left = $urandom_range(16, 96);
         end
         stall_phase_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= ~rsp_ch.ready;
            endcase
         end
      end
   end

   initial begin
      madt_case_type c;
      int unsigned   byte_goal;
      int unsigned   word_goal;
      req_ch.valid = 1'b0;
      req_ch.table_byte = 8'h00;
      req_ch.final_byte = 1'b0;
      clear_walk();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_cases[i]) run_case(directed_cases[i]);
      wait_drained();

      byte_goal = bytes_taken + RANDOM_BYTES;
      word_goal = words_taken + RANDOM_WORDS;
      while (bytes_taken < byte_goal || words_taken < word_goal) begin
         c = '0;
         c.auto_len = 1'b1;
         c.apic_base = $urandom;
         c.cpu_type = ($urandom_range(0, 9) == 0) ? 8'($urandom) : TYPE_LOCAL_APIC;
         c.cpu_entries = $urandom_range(0, 5);
         c.cpu_len = ($urandom_range(0, 9) < 7) ? MIN_CPU_ENTRY : 8'($urandom_range(0, 20));
         c.tail = tail_kind_type'($urandom_range(0, 4));
         case ($urandom_range(0, 9))
            0: begin
               c.auto_len = 1'b0;
               c.hdr_len = $urandom_range(0, 120);
               c.supplied = $urandom_range(1, 140);
            end
            1: begin
               c.auto_len = 1'b0;
               c.hdr_len = $urandom;
               c.supplied = $urandom_range(1, 140);
            end
            2: c.supplied = $urandom_range(1, 100);
            default: begin
            end
         endcase
         run_case(c);
         if ($urandom_range(0, 7) == 0) wait_drained();
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (fault_count == 0 && records_due.size() == 0) begin
         $display("madt_local_apic_parser_top_tb: clean");
      end else begin
         $display("madt_local_apic_parser_top_tb: errors");
      end
      $finish;
   end

endmodule

[madt_local_apic_parser_top.f]
sv/mlap_pkg.sv
sv/mlap_req_if.sv
sv/mlap_rsp_if.sv
sv/mlap_front.sv
sv/mlap_queue.sv
sv/mlap_back.sv
sv/madt_local_apic_parser_top.sv
test/madt_local_apic_parser_top_tb.sv
